@@ rtl/cdts_pkg.sv @@
// Package for the circling detector with thermal sector map.
// Holds sizes, codes, fixed-point constants and the item structs.
// No dependencies; the interfaces, the top level and the bench import it.
`timescale 1ns / 1ps

package cdts_pkg;

  // Sector map geometry
  localparam int unsigned NUM_SECTORS = 24;
  localparam int unsigned SEC_W       = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;

  // Field widths
  localparam int unsigned HEAD_W     = 16;
  localparam int unsigned CLIMB_W    = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RSEC_W     = 5;
  localparam int unsigned SECT_OUT_W = 5;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned FLOOR_W    = 15;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned MEM_W      = CLIMB_W + TIME_W;

  // Peak is unsigned Q7.16 and never reaches 2^23 (it only grows toward climb << 8)
  localparam int unsigned PEAK_W = 23;

  // Flight mode codes
  typedef enum logic [1:0] {
    MODE_UNDEF    = 2'd0,
    MODE_STRAIGHT = 2'd1,
    MODE_RIGHT    = 2'd2,
    MODE_LEFT     = 2'd3
  } flight_mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURN_RATE  = 1'b0,
    CFG_PEAK_FLOOR = 1'b1
  } cfg_idx_e;

  // Reset values
  localparam logic [THR_W-1:0]   THR_RST   = 16'd728;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 15'd256;
  localparam logic [PEAK_W-1:0]  PEAK_RST  = 23'd65536;

  // Turn counters
  localparam logic [CNT_W-1:0] CNT_MAX = 3'd4;
  localparam logic [CNT_W-1:0] CNT_ON  = 3'd2;

  // Heading change is scaled to per-second against threshold * dt
  localparam int unsigned TURN_SCALE = 1000;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned MAGK_W     = 26;
  localparam int unsigned LIMIT_W    = THR_W + TIME_W;

  // floor(x / 10) for x < 2^23: (x * RECIP10) >> 26
  localparam int unsigned       RECIP10_W  = 23;
  localparam int unsigned       RECIP10_SH = 26;
  localparam logic [RECIP10_W-1:0] RECIP10 = 23'd6710887;
  localparam int unsigned       Q10_W      = 20;

  // floor(x / 1000) for x < 2^24: (x * RECIP1000) >> 34
  localparam int unsigned         RECIP1000_W  = 25;
  localparam int unsigned         RECIP1000_SH = 34;
  localparam logic [RECIP1000_W-1:0] RECIP1000 = 25'd17179870;
  localparam int unsigned         Q1000_W      = 15;
  localparam int unsigned         DECAY_W      = PEAK_W + 1;
  localparam logic [DECAY_W-1:0]  DECAY_ROUND  = 24'd999;

  // Input item
  typedef struct packed {
    logic [HEAD_W-1:0]         heading;
    logic signed [CLIMB_W-1:0] climb;
    logic                      airborne;
    logic [TIME_W-1:0]         now_ms;
    logic [RSEC_W-1:0]         read_sector;
  } cdts_in_t;

  // Result item
  typedef struct packed {
    flight_mode_e              flight_mode;
    logic [SECT_OUT_W-1:0]     sector;
    logic                      sector_changed;
    logic [FLOOR_W-1:0]        peak_level;
    logic signed [CLIMB_W-1:0] read_climb;
    logic [TIME_W-1:0]         read_age_ms;
  } cdts_out_t;

endpackage

@@ rtl/cdts_ifs.sv @@
// Valid/ready channel interfaces for the input and result items.
// Depends on cdts_pkg for the payload structs.
`timescale 1ns / 1ps

interface cdts_in_if import cdts_pkg::*;;
  logic     valid;
  logic     ready;
  cdts_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdts_out_if import cdts_pkg::*;;
  logic      valid;
  logic      ready;
  cdts_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/circling_detector_thermal_sector_map_unit.sv @@
// Circling detector with thermal sector map: top level.
// Latency: a result passes the stage 1 register and then the output register.
// Throughput: one item per cycle while results are taken; an item that enters a new
//   sector holds off the next one until the peak decay (a reciprocal multiply) lands.
// Reset: all control state clears at once; per-sector valid flops make the map
//   read as zero immediately, so there is no clearing pass.
`timescale 1ns / 1ps

module circling_detector_thermal_sector_map_unit
  import cdts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cdts_in_if.sink               in_i,
  cdts_out_if.source            out_o
);

  localparam int unsigned PROD_W = HEAD_W + SEC_W;

  // Stage 1 payload
  typedef struct packed {
    flight_mode_e              mode;
    logic [SEC_W-1:0]          sec;
    logic                      changed;
    logic [PEAK_W-1:0]         pk;
    logic [TIME_W-1:0]         now;
    logic signed [CLIMB_W-1:0] climb;
    logic                      fwd;
    logic                      in_range;
    logic                      hit;
  } s1_t;

  // Configuration registers
  logic [THR_W-1:0]   thr_q;
  logic [FLOOR_W-1:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RST;
      floor_q <= FLOOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TURN_RATE:  thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_PEAK_FLOOR: floor_q <= cfg_data_i[FLOOR_W-1:0];
      endcase
    end
  end

  // State
  logic [HEAD_W-1:0]      last_head_q, last_head_d;
  logic [TIME_W-1:0]      last_time_q, last_time_d;
  logic [CNT_W-1:0]       right_q, right_d;
  logic [CNT_W-1:0]       left_q, left_d;
  logic [CNT_W-1:0]       straight_q, straight_d;
  flight_mode_e           mode_q, mode_d;
  logic [SEC_W-1:0]       cur_sec_q;
  logic [PEAK_W-1:0]      peak_q;
  logic [NUM_SECTORS-1:0] sec_valid_q;

  // Pipeline
  logic      s1_valid_q;
  s1_t       s1_q, s1_d;
  logic      out_valid_q;
  cdts_out_t out_q, out_d;

  logic in_acc, s1_adv, in_ready;

  // Handshake: hold off the next item until a sector-changing item leaves stage 1 (peak loop)
  assign s1_adv   = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_ready = ~s1_valid_q | (s1_adv & ~s1_q.changed);
  assign in_acc   = in_i.valid & in_ready;
  assign in_i.ready = in_ready;

  // Sector of the incoming heading
  logic [PROD_W-1:0] sec_prod;
  logic [SEC_W-1:0]  in_sec;
  logic              sec_chg;

  assign sec_prod = PROD_W'(in_i.data.heading) * PROD_W'(NUM_SECTORS);
  assign in_sec   = sec_prod[PROD_W-1:HEAD_W];
  assign sec_chg  = (in_sec != cur_sec_q);

  // Turn rate test: |diff| * 1000 against threshold * dt
  logic [HEAD_W-1:0]  d16;
  logic [MAG_W-1:0]   mag;
  logic [MAGK_W-1:0]  mag_k;
  logic [TIME_W-1:0]  dt;
  logic [LIMIT_W-1:0] limit;
  logic               head_chg, turn, turn_r, turn_l;

  assign head_chg = (in_i.data.heading != last_head_q);
  assign d16      = in_i.data.heading - last_head_q;
  assign mag      = d16[HEAD_W-1] ? (MAG_W'(1 << HEAD_W) - MAG_W'(d16)) : MAG_W'(d16);
  assign mag_k    = MAGK_W'(mag) * MAGK_W'(TURN_SCALE);
  assign dt       = in_i.data.now_ms - last_time_q;
  assign limit    = LIMIT_W'(thr_q) * LIMIT_W'(dt);
  assign turn     = (LIMIT_W'(mag_k) > limit);
  assign turn_r   = turn & ~d16[HEAD_W-1];
  assign turn_l   = turn & d16[HEAD_W-1];

  // Counter and mode update
  always_comb begin
    last_head_d = last_head_q;
    last_time_d = last_time_q;
    right_d     = right_q;
    left_d      = left_q;
    straight_d  = straight_q;
    mode_d      = mode_q;
    if (in_acc && head_chg) begin
      last_head_d = in_i.data.heading;
      last_time_d = in_i.data.now_ms;
      if (dt != '0) begin
        if (!in_i.data.airborne) begin
          mode_d = MODE_UNDEF;
        end else if (turn_r) begin
          if (right_q < CNT_MAX) right_d = right_q + 3'd1;
          straight_d = '0;
          if (right_d > CNT_ON) mode_d = MODE_RIGHT;
        end else if (turn_l) begin
          if (left_q < CNT_MAX) left_d = left_q + 3'd1;
          straight_d = '0;
          if (left_d > CNT_ON) mode_d = MODE_LEFT;
        end else begin
          right_d = '0;
          left_d  = '0;
          if (straight_q < CNT_MAX) straight_d = straight_q + 3'd1;
          if (straight_d > CNT_ON) mode_d = MODE_STRAIGHT;
        end
      end
    end
  end

  // Peak low pass: pk += (te - pk) / 10 when climb << 8 exceeds it
  logic signed [PEAK_W+1:0] te_s, gap;
  logic [Q10_W-1:0]         q10;
  logic [RECIP10_W+PEAK_W-1:0] prod10;
  logic [PEAK_W-1:0]        pk1;
  logic                     grow;

  assign te_s   = {in_i.data.climb[CLIMB_W-1], in_i.data.climb, 8'h00};
  assign gap    = te_s - $signed({2'b00, peak_q});
  assign grow   = ~gap[PEAK_W+1] & (gap != '0);
  assign prod10 = (RECIP10_W + PEAK_W)'(gap[PEAK_W-1:0]) * (RECIP10_W + PEAK_W)'(RECIP10);
  assign q10    = prod10[RECIP10_SH +: Q10_W];
  assign pk1    = grow ? (peak_q + PEAK_W'(q10)) : peak_q;

  // Read port setup and same-item forwarding
  logic [SEC_W-1:0] ridx;
  logic             in_range, fwd;

  assign ridx     = SEC_W'(in_i.data.read_sector);
  assign in_range = (32'(in_i.data.read_sector) < 32'(NUM_SECTORS));
  assign fwd      = sec_chg & in_range & (ridx == in_sec);

  always_comb begin
    s1_d.mode     = mode_d;
    s1_d.sec      = in_sec;
    s1_d.changed  = sec_chg;
    s1_d.pk       = sec_chg ? pk1 : peak_q;
    s1_d.now      = in_i.data.now_ms;
    s1_d.climb    = in_i.data.climb;
    s1_d.fwd      = fwd;
    s1_d.in_range = in_range;
    s1_d.hit      = in_range & (sec_valid_q[ridx] | fwd);
  end

  // Sector map: {time, climb} per sector
  logic [MEM_W-1:0] ram_rdata;

  cdts_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_SECTORS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (in_acc & sec_chg),
    .waddr_i (in_sec),
    .wdata_i ({in_i.data.now_ms, in_i.data.climb}),
    .re_i    (in_acc),
    .raddr_i (ridx),
    .rdata_o (ram_rdata)
  );

  // Stage 1: peak decay pk - ceil(pk / 1000), read-back and age
  logic [DECAY_W-1:0]                y;
  logic [DECAY_W+RECIP1000_W-1:0]    prod1000;
  logic [Q1000_W-1:0]                q1000;
  logic                              decay;
  logic [PEAK_W-1:0]                 pk_fin;
  logic signed [CLIMB_W-1:0]         rd_climb;
  logic [TIME_W-1:0]                 rd_time;

  assign y        = DECAY_W'(s1_q.pk) + DECAY_ROUND;
  assign prod1000 = (DECAY_W + RECIP1000_W)'(y) * (DECAY_W + RECIP1000_W)'(RECIP1000);
  assign q1000    = prod1000[RECIP1000_SH +: Q1000_W];
  assign decay    = s1_q.changed & (s1_q.pk > {floor_q, 8'h00});
  assign pk_fin   = decay ? (s1_q.pk - PEAK_W'(q1000)) : s1_q.pk;
  assign rd_climb = s1_q.fwd ? s1_q.climb : $signed(ram_rdata[CLIMB_W-1:0]);
  assign rd_time  = s1_q.fwd ? s1_q.now : ram_rdata[MEM_W-1:CLIMB_W];

  always_comb begin
    out_d.flight_mode    = s1_q.mode;
    out_d.sector         = SECT_OUT_W'(s1_q.sec);
    out_d.sector_changed = s1_q.changed;
    out_d.peak_level     = pk_fin[PEAK_W-1:8];
    out_d.read_climb     = s1_q.hit ? rd_climb : '0;
    if (!s1_q.in_range) begin
      out_d.read_age_ms = '0;
    end else if (s1_q.hit) begin
      out_d.read_age_ms = s1_q.now - rd_time;
    end else begin
      out_d.read_age_ms = s1_q.now;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_head_q <= '0;
      last_time_q <= '0;
      right_q     <= '0;
      left_q      <= '0;
      straight_q  <= '0;
      mode_q      <= MODE_UNDEF;
      cur_sec_q   <= '0;
      peak_q      <= PEAK_RST;
      sec_valid_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      last_head_q <= last_head_d;
      last_time_q <= last_time_d;
      right_q     <= right_d;
      left_q      <= left_d;
      straight_q  <= straight_d;
      mode_q      <= mode_d;
      if (in_acc && sec_chg) begin
        cur_sec_q           <= in_sec;
        sec_valid_q[in_sec] <= 1'b1;
      end
      if (s1_adv && s1_q.changed) begin
        peak_q <= pk_fin;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A sector-changing item keeps ready low in the cycle after its accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && sec_chg) |=> !in_ready)
    else $error("item accepted behind a pending peak update");

  // Turn counters saturate at their maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (right_q <= CNT_MAX) && (left_q <= CNT_MAX) && (straight_q <= CNT_MAX))
    else $error("turn counter beyond saturation");

  // A stage 1 item is never dropped without moving on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("stage 1 item lost");

  // Sector valid flags only ever set after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((sec_valid_q & $past(sec_valid_q)) == $past(sec_valid_q)))
    else $error("sector valid flag cleared");

endmodule

@@ rtl/cdts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cdts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                               wdata_i,
  input  logic                                           re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port; a same-address read in the same cycle returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ verif/circling_detector_thermal_sector_map_unit_tb.sv @@
// Self-checking bench for the circling detector / thermal sector map unit.
// Directed table, then flight-like random items over several register settings.
// Depends on cdts_pkg, cdts_ifs and the unit's top level.
`timescale 1ns / 1ps

module circling_detector_thermal_sector_map_unit_tb;
  import cdts_pkg::*;

  // Clock, reset, register port
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  always #2 clk_i = ~clk_i;

  cdts_in_if  in_if ();
  cdts_out_if out_if ();

  circling_detector_thermal_sector_map_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Tracked copy of the unit's state and registers
  logic [THR_W-1:0]          trk_thr    = THR_RST;
  logic [FLOOR_W-1:0]        trk_floor  = FLOOR_RST;
  logic [HEAD_W-1:0]         trk_last_heading = '0;
  logic [TIME_W-1:0]         trk_last_time    = '0;
  logic [CNT_W-1:0]          trk_right = '0;
  logic [CNT_W-1:0]          trk_left  = '0;
  logic [CNT_W-1:0]          trk_straight = '0;
  flight_mode_e              trk_mode  = MODE_UNDEF;
  int unsigned               trk_sector = 0;
  longint                    trk_peak  = 65536;
  logic signed [CLIMB_W-1:0] trk_sec_climb [NUM_SECTORS];
  logic [TIME_W-1:0]         trk_sec_time  [NUM_SECTORS];

  cdts_out_t tick_results_q [$];
  int        n_fail  = 0;
  int        n_seen  = 0;
  int        tx_quiet_left = 0;
  int        rx_quiet_left = 0;

  // Directed table
  typedef struct {
    cdts_in_t  item;
    bit        typed;
    cdts_out_t want;
  } dir_row_t;
  dir_row_t dir_rows [$];

  // Flight-like generator state
  typedef enum int {SEG_RIGHT, SEG_LEFT, SEG_STRAIGHT, SEG_NOISE} seg_kind_e;
  seg_kind_e         g_seg  = SEG_NOISE;
  int                g_left = 0;
  int                g_step = 0;
  logic [HEAD_W-1:0] g_heading;
  logic [TIME_W-1:0] g_time;

  // One tick of the unit: mode, sector map, peak and readback
  function automatic cdts_out_t predict_tick(input cdts_in_t it);
    cdts_out_t         r;
    logic [HEAD_W-1:0] d16;
    int                diff;
    logic [TIME_W-1:0] dt;
    longint            limit;
    int unsigned       sec;
    longint            te;
    longint            pk;
    longint            po;
    r = '0;
    if (it.heading != trk_last_heading) begin
      d16 = it.heading - trk_last_heading;
      diff = int'($signed(d16));
      dt = it.now_ms - trk_last_time;
      trk_last_time = it.now_ms;
      if (dt != 0) begin
        limit = longint'(trk_thr) * longint'(dt);
        if (!it.airborne) begin
          trk_mode = MODE_UNDEF;
        end else if (diff > 0 && longint'(diff) * 1000 > limit) begin
          if (trk_right < CNT_MAX) trk_right++;
          trk_straight = '0;
          if (trk_right > CNT_ON) trk_mode = MODE_RIGHT;
        end else if (diff < 0 && -longint'(diff) * 1000 > limit) begin
          if (trk_left < CNT_MAX) trk_left++;
          trk_straight = '0;
          if (trk_left > CNT_ON) trk_mode = MODE_LEFT;
        end else begin
          trk_left = '0;
          trk_right = '0;
          if (trk_straight < CNT_MAX) trk_straight++;
          if (trk_straight > CNT_ON) trk_mode = MODE_STRAIGHT;
        end
      end
      trk_last_heading = it.heading;
    end

    sec = (int'(it.heading) * NUM_SECTORS) >> 16;
    if (sec >= NUM_SECTORS) sec = NUM_SECTORS - 1;
    r.sector_changed = 1'b0;
    if (sec != trk_sector) begin
      r.sector_changed = 1'b1;
      trk_sector = sec;
      // low-pass toward a higher climb, then slow decay above the floor
      te = longint'($signed(it.climb)) * 256;
      pk = trk_peak;
      if (te > pk) pk += (te - pk) / 10;
      if (pk > longint'(trk_floor) * 256) pk = (pk * 999) / 1000;
      trk_peak = pk;
      trk_sec_climb[sec] = it.climb;
      trk_sec_time[sec]  = it.now_ms;
    end

    if (it.read_sector < NUM_SECTORS) begin
      r.read_climb  = trk_sec_climb[it.read_sector];
      r.read_age_ms = it.now_ms - trk_sec_time[it.read_sector];
    end

    po = trk_peak >>> 8;
    if (po > 32767) po = 32767;
    r.flight_mode = trk_mode;
    r.sector      = SECT_OUT_W'(sec);
    r.peak_level  = FLOOR_W'(po);
    return r;
  endfunction

  function automatic void add_row(input logic [HEAD_W-1:0] h,
                                  input logic [CLIMB_W-1:0] c, input bit a,
                                  input logic [TIME_W-1:0] t,
                                  input logic [RSEC_W-1:0] rs,
                                  input bit typed = 1'b0,
                                  input cdts_out_t w = '0);
    dir_row_t row;
    row.item.heading     = h;
    row.item.climb       = c;
    row.item.airborne    = a;
    row.item.now_ms      = t;
    row.item.read_sector = rs;
    row.typed = typed;
    row.want  = w;
    dir_rows.push_back(row);
  endfunction

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    if (tx_quiet_left > 0) begin
      tx_quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) tx_quiet_left = $urandom_range(15, 50);
    return pick_gap();
  endfunction

  // Segments of turning, straight flight and noise
  function automatic cdts_in_t next_flight_item();
    cdts_in_t          it;
    logic [TIME_W-1:0] dt;
    int                p;
    if (g_left == 0) begin
      g_left = $urandom_range(4, 30);
      p = $urandom_range(0, 9);
      if (p < 3) g_seg = SEG_RIGHT;
      else if (p < 6) g_seg = SEG_LEFT;
      else if (p < 9) g_seg = SEG_STRAIGHT;
      else g_seg = SEG_NOISE;
      g_step = $urandom_range(300, 5000);
    end
    g_left--;

    p = $urandom_range(0, 19);
    if (p == 0) dt = '0;
    else if (p == 1) dt = $urandom_range(1000, 60000);
    else if (p == 2) dt = $urandom;
    else dt = $urandom_range(20, 250);
    g_time += dt;

    case (g_seg)
      SEG_RIGHT: begin
        g_heading += HEAD_W'(g_step + $urandom_range(0, 200));
      end
      SEG_LEFT: begin
        g_heading -= HEAD_W'(g_step + $urandom_range(0, 200));
      end
      SEG_STRAIGHT: begin
        if ($urandom_range(0, 3) != 0) g_heading += HEAD_W'($urandom_range(0, 40) - 20);
      end
      default: begin
        g_heading = $urandom;
        if ($urandom_range(0, 1) == 1) g_time = $urandom;
      end
    endcase

    it.heading  = g_heading;
    it.now_ms   = g_time;
    it.airborne = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 9) == 0) it.climb = $urandom;
    else it.climb = CLIMB_W'($urandom_range(0, 1536)) - CLIMB_W'(512);
    if ($urandom_range(0, 7) == 0) it.read_sector = RSEC_W'($urandom_range(24, 31));
    else it.read_sector = RSEC_W'($urandom_range(0, NUM_SECTORS - 1));
    return it;
  endfunction

  // Offer one item, hold until accepted, then queue its expected result
  task automatic push_item(input cdts_in_t it, input bit typed, input cdts_out_t want);
    cdts_out_t pred;
    int        gap;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pred = predict_tick(it);
    tick_results_q.push_back(typed ? want : pred);
    gap = tx_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Both registers, written back to back while idle
  task automatic write_regs(input logic [THR_W-1:0] thr, input logic [FLOOR_W-1:0] flr);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TURN_RATE;
    cfg_data <= CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_idx  <= CFG_PEAK_FLOOR;
    cfg_data <= CFG_DATA_W'(flr);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    trk_thr   = thr;
    trk_floor = flr;
  endtask

  task automatic run_flight(input int n);
    for (int i = 0; i < n; i++) push_item(next_flight_item(), 1'b0, '0);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    cdts_out_t got;
    cdts_out_t exp_r;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      got = out_if.data;
      n_seen++;
      if (tick_results_q.size() == 0) begin
        if (n_fail < 10) $display("unexpected result %0d: %p", n_seen, got);
        n_fail++;
      end else begin
        exp_r = tick_results_q.pop_front();
        if (got.flight_mode !== exp_r.flight_mode || got.sector !== exp_r.sector ||
            got.sector_changed !== exp_r.sector_changed ||
            got.peak_level !== exp_r.peak_level || got.read_climb !== exp_r.read_climb ||
            got.read_age_ms !== exp_r.read_age_ms) begin
          if (n_fail < 10) begin
            $display("result %0d mismatch", n_seen);
            $display("  exp mode=%0d sec=%0d chg=%0b peak=%0d rclimb=%0d age=%0d",
                     exp_r.flight_mode, exp_r.sector, exp_r.sector_changed,
                     exp_r.peak_level, exp_r.read_climb, exp_r.read_age_ms);
            $display("  got mode=%0d sec=%0d chg=%0b peak=%0d rclimb=%0d age=%0d",
                     got.flight_mode, got.sector, got.sector_changed,
                     got.peak_level, got.read_climb, got.read_age_ms);
          end
          n_fail++;
        end
      end
    end
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin : rx_drive
    int stall_left;
    bit long_done;
    stall_left = 0;
    long_done  = 1'b0;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_done && n_seen >= 60) begin
        long_done  = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (rx_quiet_left > 0) begin
        out_if.ready <= 1'b1;
        rx_quiet_left--;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_quiet_left = $urandom_range(15, 50);
        stall_left = pick_gap();
        if (stall_left == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          stall_left--;
        end
      end
      @(posedge clk_i);
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stim
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_TURN_RATE;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.data    <= '0;
    for (int s = 0; s < NUM_SECTORS; s++) begin
      trk_sec_climb[s] = '0;
      trk_sec_time[s]  = '0;
    end
    g_heading = $urandom;
    g_time    = $urandom;

    // after reset: no turn, empty map, peak at 1.0 m/s
    add_row(16'h0000, 16'sh0000, 1'b1, 32'd100, 5'd0, 1'b1,
            '{MODE_UNDEF, 5'd0, 1'b0, 15'd256, 16'sh0000, 32'd100});
    // read beyond the last sector
    add_row(16'h0000, 16'sh0000, 1'b1, 32'd200, 5'd31, 1'b1,
            '{MODE_UNDEF, 5'd0, 1'b0, 15'd256, 16'sh0000, 32'd0});
    // never written sector ages with the clock
    add_row(16'h0000, 16'sh0000, 1'b1, 32'hFFFF_FFFF, 5'd23, 1'b1,
            '{MODE_UNDEF, 5'd0, 1'b0, 15'd256, 16'sh0000, 32'hFFFF_FFFF});
    // top heading enters the last sector, readback sees the same-tick write
    add_row(16'hFFFF, 16'sh8000, 1'b1, 32'd5, 5'd23, 1'b1,
            '{MODE_UNDEF, 5'd23, 1'b1, 15'd256, 16'sh8000, 32'd0});
    add_row(16'hFFFF, 16'sh7FFF, 1'b1, 32'd10, 5'd24);
    // right turns up to circling right, peak grows on max climb
    add_row(16'h0500, 16'sh7FFF, 1'b1, 32'd110, 5'd0);
    add_row(16'h0A00, 16'sh7FFF, 1'b1, 32'd120, 5'd23);
    add_row(16'h0F00, 16'sh7FFF, 1'b1, 32'd130, 5'd1);
    // heading change with no elapsed time
    add_row(16'h1400, 16'sh7FFF, 1'b1, 32'd130, 5'd1);
    // on the ground
    add_row(16'h1900, 16'sh0100, 1'b0, 32'd140, 5'd2);
    // left turns, across north
    add_row(16'h1000, 16'shFF9C, 1'b1, 32'd150, 5'd1);
    add_row(16'h0700, 16'shFF9C, 1'b1, 32'd160, 5'd0);
    add_row(16'hFE00, 16'shFF9C, 1'b1, 32'd170, 5'd23);
    // slow drift counts as straight
    add_row(16'hFE01, 16'sh0040, 1'b1, 32'd1170, 5'd23);
    add_row(16'hFE02, 16'sh0040, 1'b1, 32'd2170, 5'd0);
    add_row(16'hFE03, 16'sh0040, 1'b1, 32'd3170, 5'd5);
    // half-turn steps wrap to the most negative difference
    add_row(16'h7E03, 16'sh8000, 1'b1, 32'd3171, 5'd12);
    add_row(16'hFE03, 16'sh7FFF, 1'b1, 32'd3172, 5'd23);
    // elapsed time across the clock wrap
    add_row(16'h1000, 16'sh0000, 1'b1, 32'hFFFF_FFF0, 5'd23);
    add_row(16'h2000, 16'sh0000, 1'b1, 32'h0000_0010, 5'd2);
    add_row(16'h8000, 16'sh7FFF, 1'b1, 32'd20, 5'd12);
    add_row(16'h8000, 16'sh8000, 1'b0, 32'd30, 5'd30);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    run_flight(80);
    drain_results();

    // lowest settings: every timed airborne heading change turns, peak decays on each sector change
    write_regs(16'd0, 15'd0);
    run_flight(80);
    drain_results();

    // highest settings: peak never decays
    write_regs(16'hFFFF, 15'h7FFF);
    run_flight(80);
    drain_results();

    write_regs(THR_W'($urandom_range(200, 3000)), FLOOR_W'($urandom_range(0, 32767)));
    run_flight(80);
    drain_results();

    write_regs(THR_W'($urandom), FLOOR_W'($urandom_range(0, 600)));
    run_flight(80);
    drain_results();

    repeat (8) @(posedge clk_i);
    if (n_fail == 0 && tick_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cdts_pkg.sv
rtl/cdts_ifs.sv
rtl/cdts_ram.sv
rtl/circling_detector_thermal_sector_map_unit.sv
verif/circling_detector_thermal_sector_map_unit_tb.sv
